@@ design/bld_pkg.sv @@
// Shared types and constants of the block-linear deswizzle address generator.
`timescale 1ns / 1ps

package bld_pkg;

    // Fixed field widths
    localparam int X_W      = 12;   // block_x / block_y
    localparam int OFF_W    = 28;   // source_offset / dest_offset
    localparam int IMG_W    = 15;   // image_width / image_height
    localparam int BPB_W    = 3;    // bytes_per_block_log2
    localparam int DL_W     = 29;   // data_length
    localparam int CFG_IDX_W = 2;
    localparam int LOW_W    = 10;   // interleaved low address bits
    localparam int NUM_STEPS = 3;   // interleave passes at most

    // Register reset values
    localparam logic [IMG_W-1:0] IMG_W_RST = IMG_W'(16);
    localparam logic [IMG_W-1:0] IMG_H_RST = IMG_W'(16);
    localparam logic [BPB_W-1:0] BPB_RST   = BPB_W'(4);
    localparam logic [DL_W-1:0]  DL_RST    = '0;

    // Register indexes of the configuration port
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_IMAGE_WIDTH  = 2'd0,
        REG_IMAGE_HEIGHT = 2'd1,
        REG_BPB_LOG2     = 2'd2,
        REG_DATA_LENGTH  = 2'd3
    } t_reg_idx;

    // One interleave pass: x bits then y bits at offset xo+yo
    typedef struct packed {
        logic       act;
        logic       xc;    // x bits taken (0 or 1)
        logic [2:0] yc;    // y bits taken (0..4)
        logic [1:0] xo;    // x bits used before this pass
        logic [2:0] yo;    // y bits used before this pass
    } t_swz_step;

    // Swizzle schedule derived from the configuration
    typedef struct packed {
        t_swz_step [NUM_STEPS-1:0] step;
        logic [1:0] xu;    // total x bits interleaved
        logic [2:0] yu;    // total y bits interleaved
        logic       p4;    // 16-byte blocks (else 8-byte)
    } t_swz;

endpackage

@@ design/bld_cfg.sv @@
// Configuration registers and derived block-grid geometry.
`timescale 1ns / 1ps

module bld_cfg
    import bld_pkg::*;
#(
    parameter int MAX_BLOCKS_PER_SIDE = 4096,
    localparam int BLK_W = $clog2(MAX_BLOCKS_PER_SIDE + 1),
    localparam int LG_W  = $clog2(BLK_W + 1)
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [DL_W-1:0]      i_cfg_data,
    output t_swz                 o_swz,
    output logic [BLK_W-1:0]     o_bw,
    output logic [BLK_W:0]       o_row_sh,
    output logic [DL_W-1:0]      o_dl
);

    logic [IMG_W-1:0] r_img_w;
    logic [IMG_W-1:0] r_img_h;
    logic [BPB_W-1:0] r_bpb_lg;
    logic [DL_W-1:0]  r_dl;

    t_swz             r_swz, n_swz;
    logic [BLK_W-1:0] r_bw, n_bw;
    logic [BLK_W:0]   r_row_sh, n_row_sh;

    logic [BLK_W-1:0] bh;
    logic [LG_W-1:0]  xb, yb;
    logic             p4;
    logic [BLK_W:0]   row;

    // schedule walk temporaries
    logic             run;
    logic             xc;
    logic [2:0]       yc;
    logic [1:0]       xu;
    logic [2:0]       yu;
    logic [4:0]       ydiff, ydbl;

    // ceil(log2(v)), zero for zero
    function automatic logic [LG_W-1:0] log2c(input logic [BLK_W-1:0] v);
        logic [LG_W-1:0] r;
        r = '0;
        for (int n = BLK_W; n >= 0; n--) begin
            if (((BLK_W + 1)'(1) << n) >= (BLK_W + 1)'(v)) r = LG_W'(n);
        end
        return r;
    endfunction

    // half of 2^k plus a third of that half
    function automatic logic [15:0] near_pow_lim(input logic [3:0] k);
        logic [15:0] r;
        case (k)
            4'd0:    r = 16'd0;
            4'd1:    r = 16'd1;
            4'd2:    r = 16'd2;
            4'd3:    r = 16'd5;
            4'd4:    r = 16'd10;
            4'd5:    r = 16'd21;
            4'd6:    r = 16'd42;
            4'd7:    r = 16'd85;
            4'd8:    r = 16'd170;
            4'd9:    r = 16'd341;
            4'd10:   r = 16'd682;
            4'd11:   r = 16'd1365;
            4'd12:   r = 16'd2730;
            4'd13:   r = 16'd5461;
            default: r = 16'd0;
        endcase
        return r;
    endfunction

    // pixel count to block count, saturated
    function automatic logic [BLK_W-1:0] blocks_of(input logic [IMG_W-1:0] px);
        logic [IMG_W+1:0] b;
        b = ((IMG_W + 2)'(px) + (IMG_W + 2)'(3)) >> 2;
        if (b > (IMG_W + 2)'(MAX_BLOCKS_PER_SIDE)) return BLK_W'(MAX_BLOCKS_PER_SIDE);
        return BLK_W'(b);
    endfunction

    // Write registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_img_w  <= IMG_W_RST;
            r_img_h  <= IMG_H_RST;
            r_bpb_lg <= BPB_RST;
            r_dl     <= DL_RST;
        end else if (i_cfg_valid) begin
            case (t_reg_idx'(i_cfg_index))
                REG_IMAGE_WIDTH:  r_img_w  <= i_cfg_data[IMG_W-1:0];
                REG_IMAGE_HEIGHT: r_img_h  <= i_cfg_data[IMG_W-1:0];
                REG_BPB_LOG2:     r_bpb_lg <= i_cfg_data[BPB_W-1:0];
                REG_DATA_LENGTH:  r_dl     <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Derive grid size, bit counts and interleave schedule
    always_comb begin
        p4   = (r_bpb_lg >= BPB_W'(4));
        n_bw = blocks_of(r_img_w);
        bh   = blocks_of(r_img_h);
        xb   = log2c(n_bw);
        yb   = log2c(bh);

        // drop one y bit for heights just over a power of two
        if ((|(bh & (bh - BLK_W'(1)))) && (16'(bh) <= near_pow_lim(4'(yb)))
            && (yb > LG_W'(3))) begin
            yb = yb - LG_W'(1);
        end

        // pad row width to a multiple of 4 or 8 blocks
        if (p4) row = ((BLK_W + 1)'(n_bw) + (BLK_W + 1)'(3)) & ~(BLK_W + 1)'(3);
        else    row = ((BLK_W + 1)'(n_bw) + (BLK_W + 1)'(7)) & ~(BLK_W + 1)'(7);

        // walk the interleave passes
        run   = 1'b1;
        xc    = !p4;
        yc    = 3'd1;
        xu    = 2'd0;
        yu    = 3'd0;
        ydiff = '0;
        ydbl  = '0;
        n_swz = '0;
        for (int i = 0; i < NUM_STEPS; i++) begin
            if (run && (3'(xu) < (p4 ? 3'd2 : 3'd3))
                && ((5'(xu) + 5'(xc)) < 5'(xb))) begin
                n_swz.step[i].act = 1'b1;
                n_swz.step[i].xc  = xc;
                n_swz.step[i].yc  = yc;
                n_swz.step[i].xo  = xu;
                n_swz.step[i].yo  = yu;
                xu = xu + 2'(xc);
                yu = yu + yc;
                xc = (5'(xb) > 5'(xu));
                ydbl = 5'(yc) << 1;
                if (5'(yb) <= 5'(yu)) begin
                    yc = 3'd0;
                end else begin
                    ydiff = 5'(yb) - 5'(yu);
                    yc = 3'((ydiff < ydbl) ? ydiff : ydbl);
                end
            end else begin
                run = 1'b0;
            end
        end
        n_swz.xu = xu;
        n_swz.yu = yu;
        n_swz.p4 = p4;
        n_row_sh = row >> xu;
    end

    // Hold derived geometry
    always_ff @(posedge i_clk) begin
        r_swz    <= n_swz;
        r_bw     <= n_bw;
        r_row_sh <= n_row_sh;
    end

    assign o_cfg_ready = 1'b1;
    assign o_swz       = r_swz;
    assign o_bw        = r_bw;
    assign o_row_sh    = r_row_sh;
    assign o_dl        = r_dl;

endmodule

@@ design/bld_pipe.sv @@
// Four-stage address pipeline: interleave, multiply, assemble and bound check.
`timescale 1ns / 1ps

module bld_pipe
    import bld_pkg::*;
#(
    parameter int MAX_BLOCKS_PER_SIDE = 4096,
    localparam int BLK_W = $clog2(MAX_BLOCKS_PER_SIDE + 1),
    localparam int PW    = X_W + BLK_W + 1,
    localparam int SRC_W = PW + 1 + LOW_W + 4,
    localparam int DST_W = PW + 4,
    localparam int CMP_W = SRC_W + 1
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  logic [X_W-1:0]   i_x,
    input  logic [X_W-1:0]   i_y,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output logic [OFF_W-1:0] o_src,
    output logic [OFF_W-1:0] o_dst,
    output logic             o_ok,
    input  t_swz             i_swz,
    input  logic [BLK_W-1:0] i_bw,
    input  logic [BLK_W:0]   i_row_sh,
    input  logic [DL_W-1:0]  i_dl
);

    logic en1, en2, en3, en4;

    logic                 r_s1_v, r_s2_v, r_s3_v, r_s4_v;
    logic [X_W-1:0]       r_s1_x, r_s1_y;
    logic [LOW_W-1:0]     r_s2_low, r_s3_low;
    logic [X_W-1:0]       r_s2_x, r_s2_xr, r_s2_yr, r_s3_xr;
    logic [X_W+BLK_W-1:0] r_s2_dmul;
    logic [PW-1:0]        r_s3_smul;
    logic [DST_W-1:0]     r_s3_dst;
    logic                 r_s3_dok;
    logic [OFF_W-1:0]     r_s4_src, r_s4_dst;
    logic                 r_s4_ok;

    logic [LOW_W-1:0]     n_low;
    logic [X_W-1:0]       xs, ys;
    logic                 xf;
    logic [3:0]           yf, ymask;
    logic [4:0]           fld;
    logic [X_W+BLK_W-1:0] n_dmul;
    logic [PW-1:0]        n_smul, dsum;
    logic [DST_W-1:0]     n_dst;
    logic [PW:0]          ssum;
    logic [SRC_W-1:0]     src;
    logic [CMP_W-1:0]     bpb;

    // Ready ripples back; a stage loads when empty or draining
    assign en4        = !r_s4_v || i_out_ready;
    assign en3        = !r_s3_v || en4;
    assign en2        = !r_s2_v || en3;
    assign en1        = !r_s1_v || en2;
    assign o_in_ready = en1;
    assign bpb        = i_swz.p4 ? CMP_W'(16) : CMP_W'(8);

    // Advance valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
            r_s2_v <= 1'b0;
            r_s3_v <= 1'b0;
            r_s4_v <= 1'b0;
        end else begin
            if (en1) r_s1_v <= i_in_valid;
            if (en2) r_s2_v <= r_s1_v;
            if (en3) r_s3_v <= r_s2_v;
            if (en4) r_s4_v <= r_s3_v;
        end
    end

    // Stage 1: capture coordinates
    always_ff @(posedge i_clk) begin
        if (en1 && i_in_valid) begin
            r_s1_x <= i_x;
            r_s1_y <= i_y;
        end
    end

    // Stage 2: interleave low bits, split off high bits, row product of linear offset
    always_comb begin
        n_low = '0;
        xs    = '0;
        ys    = '0;
        xf    = 1'b0;
        yf    = '0;
        ymask = '0;
        fld   = '0;
        for (int i = 0; i < NUM_STEPS; i++) begin
            if (i_swz.step[i].act) begin
                xs    = r_s1_x >> i_swz.step[i].xo;
                ys    = r_s1_y >> i_swz.step[i].yo;
                xf    = xs[0] & i_swz.step[i].xc;
                ymask = 4'((5'd1 << i_swz.step[i].yc) - 5'd1);
                yf    = ys[3:0] & ymask;
                fld   = (5'(yf) << i_swz.step[i].xc) | 5'(xf);
                n_low = n_low | (LOW_W'(fld)
                        << (4'(i_swz.step[i].xo) + 4'(i_swz.step[i].yo)));
            end
        end
        n_dmul = (X_W + BLK_W)'(r_s1_y) * (X_W + BLK_W)'(i_bw);
    end

    always_ff @(posedge i_clk) begin
        if (en2 && r_s1_v) begin
            r_s2_low  <= n_low;
            r_s2_x    <= r_s1_x;
            r_s2_xr   <= r_s1_x >> i_swz.xu;
            r_s2_yr   <= r_s1_y >> i_swz.yu;
            r_s2_dmul <= n_dmul;
        end
    end

    // Stage 3: swizzled row product, finish and check linear offset
    always_comb begin
        n_smul = PW'(r_s2_yr) * PW'(i_row_sh);
        dsum   = PW'(r_s2_dmul) + PW'(r_s2_x);
        n_dst  = DST_W'(dsum) << (i_swz.p4 ? 3'd4 : 3'd3);
    end

    always_ff @(posedge i_clk) begin
        if (en3 && r_s2_v) begin
            r_s3_smul <= n_smul;
            r_s3_xr   <= r_s2_xr;
            r_s3_low  <= r_s2_low;
            r_s3_dst  <= n_dst;
            r_s3_dok  <= (CMP_W'(n_dst) + bpb) <= CMP_W'(i_dl);
        end
    end

    // Stage 4: assemble swizzled offset and check it
    always_comb begin
        ssum = (PW + 1)'(r_s3_smul) + (PW + 1)'(r_s3_xr);
        src  = (SRC_W'(ssum) << (4'(i_swz.xu) + 4'(i_swz.yu))) | SRC_W'(r_s3_low);
        src  = src << (i_swz.p4 ? 3'd4 : 3'd3);
    end

    always_ff @(posedge i_clk) begin
        if (en4 && r_s3_v) begin
            r_s4_src <= OFF_W'(src);
            r_s4_dst <= OFF_W'(r_s3_dst);
            r_s4_ok  <= r_s3_dok && ((CMP_W'(src) + bpb) <= CMP_W'(i_dl));
        end
    end

    assign o_out_valid = r_s4_v;
    assign o_src       = r_s4_src;
    assign o_dst       = r_s4_dst;
    assign o_ok        = r_s4_ok;

    // An accepted beat always lands in stage 1
    a_accept_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> r_s1_v)
        else $error("accepted beat lost at stage 1");

    // A stalled middle stage keeps its item
    a_stage2_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s2_v && !en3 |=> r_s2_v && $stable(r_s2_xr) && $stable(r_s2_dmul))
        else $error("stage 2 item changed while stalled");

    // Offsets are whole blocks of at least eight bytes
    a_offset_align: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s4_v |-> (r_s4_src[2:0] == 3'd0) && (r_s4_dst[2:0] == 3'd0))
        else $error("offset not block aligned");

    // A copy is only valid when the data holds at least one block
    a_ok_needs_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s4_v && r_s4_ok |-> (i_dl >= DL_W'(8)))
        else $error("copy flagged valid with too little data");

    // A full, stalled pipeline takes no new beat
    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_v && r_s2_v && r_s3_v && r_s4_v && !i_out_ready |-> !o_in_ready)
        else $error("input accepted into a full pipeline");

endmodule

@@ design/block_linear_deswizzle_address_top.sv @@
// Top level of the block-linear deswizzle address generator.
//
//  Channel  Dir  Handshake                  Payload
//  s        in   i_s_tvalid / o_s_tready    tdata: block_x, block_y
//  m        out  o_m_tvalid / i_m_tready    tdata: source_offset, dest_offset
//                                           tuser: copy_valid
//  cfg      in   i_cfg_valid / o_cfg_ready  index, data (always ready)
//
// One block address per cycle while the master side takes results; an accepted beat passes
// through the four register stages of the address pipeline to its result on the master side.
// Derived grid geometry is registered behind the configuration registers.
// Synchronous active-low reset clears the stage valid bits and the registers to
// 16 x 16 pixels, 16-byte blocks and zero data length.
// Each stage loads when empty or draining, so bubbles collapse under a stall.
`timescale 1ns / 1ps

module block_linear_deswizzle_address_top
    import bld_pkg::*;
#(
    parameter int MAX_BLOCKS_PER_SIDE = 4096
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // input beats
    input  logic                 i_s_tvalid,
    output logic                 o_s_tready,
    input  logic [23:0]          i_s_tdata,   // [11:0] block_x, [23:12] block_y
    // result beats
    output logic                 o_m_tvalid,
    input  logic                 i_m_tready,
    output logic [55:0]          o_m_tdata,   // [27:0] source_offset, [55:28] dest_offset
    output logic [0:0]           o_m_tuser,   // [0] copy_valid
    // register writes
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [DL_W-1:0]      i_cfg_data
);

    localparam int BLK_W = $clog2(MAX_BLOCKS_PER_SIDE + 1);

    t_swz             swz;
    logic [BLK_W-1:0] bw;
    logic [BLK_W:0]   row_sh;
    logic [DL_W-1:0]  dl;
    logic [OFF_W-1:0] src, dst;
    logic             ok;

    // Registers and geometry
    bld_cfg #(
        .MAX_BLOCKS_PER_SIDE(MAX_BLOCKS_PER_SIDE)
    ) u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_swz       (swz),
        .o_bw        (bw),
        .o_row_sh    (row_sh),
        .o_dl        (dl)
    );

    // Address pipeline
    bld_pipe #(
        .MAX_BLOCKS_PER_SIDE(MAX_BLOCKS_PER_SIDE)
    ) u_pipe (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_tvalid),
        .o_in_ready  (o_s_tready),
        .i_x         (i_s_tdata[11:0]),
        .i_y         (i_s_tdata[23:12]),
        .o_out_valid (o_m_tvalid),
        .i_out_ready (i_m_tready),
        .o_src       (src),
        .o_dst       (dst),
        .o_ok        (ok),
        .i_swz       (swz),
        .i_bw        (bw),
        .i_row_sh    (row_sh),
        .i_dl        (dl)
    );

    assign o_m_tdata = {dst, src};
    assign o_m_tuser = ok;

endmodule

@@ tb/tb_block_linear_deswizzle_address_top.sv @@
// Testbench for the block-linear deswizzle address generator, self-checking against a predictor.
`timescale 1ns / 1ps

module tb_block_linear_deswizzle_address_top;
    import bld_pkg::*;

    localparam int MAX_BLOCKS = 4096;

    // Expected offsets of one block
    typedef struct {
        logic [OFF_W-1:0] src;
        logic [OFF_W-1:0] dst;
        logic             copy_ok;
    } t_blk_addr;

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_s_tvalid  = 1'b0;
    logic                 o_s_tready;
    logic [23:0]          i_s_tdata   = '0;   // [11:0] block_x, [23:12] block_y
    logic                 o_m_tvalid;
    logic                 i_m_tready  = 1'b0;
    logic [55:0]          o_m_tdata;          // [27:0] source_offset, [55:28] dest_offset
    logic [0:0]           o_m_tuser;          // [0] copy_valid
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [DL_W-1:0]      i_cfg_data  = '0;

    // Shadow copy of the registers
    logic [IMG_W-1:0] cfg_width  = IMG_W_RST;
    logic [IMG_W-1:0] cfg_height = IMG_H_RST;
    logic [BPB_W-1:0] cfg_bpb    = BPB_RST;
    logic [DL_W-1:0]  cfg_length = DL_RST;

    t_blk_addr pending_addrs[$];
    int        blocks_sent   = 0;
    int        addrs_checked = 0;
    int        settings_used = 0;
    int        fail_count    = 0;
    int        idle_pct      = 0;
    int        stall_pct     = 0;

    block_linear_deswizzle_address_top #(
        .MAX_BLOCKS_PER_SIDE(MAX_BLOCKS)
    ) u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // Pixels to 4x4 blocks, saturated per side
    function automatic longint unsigned grid_blocks(input logic [IMG_W-1:0] pixels);
        longint unsigned b;
        b = (longint'(pixels) + 3) >> 2;
        if (b > 64'(MAX_BLOCKS)) b = 64'(MAX_BLOCKS);
        return b;
    endfunction

    // Bits needed to index v entries; zero entries need none
    function automatic longint ceil_log2(input longint unsigned v);
        longint n;
        n = 0;
        while (n < 40 && (64'd1 << n) < v) n++;
        return n;
    endfunction

    // Swizzled and linear offsets of one block under the shadow registers
    function automatic t_blk_addr predict_offsets(input logic [X_W-1:0] bx,
                                                   input logic [X_W-1:0] by);
        longint unsigned p, bpb, bw, bh, pow_h, hh, pad, row;
        longint unsigned x, y, xm, ym, addr, src, dst;
        longint          xb, yb, xbase, xcnt, ycnt, xused, yused, t;
        int              guard;
        t_blk_addr       r;
        p = 64'(cfg_bpb);
        if (p < 3) p = 3;
        if (p > 4) p = 4;
        bpb = 64'd1 << p;
        bw  = grid_blocks(cfg_width);
        bh  = grid_blocks(cfg_height);
        xb  = ceil_log2(bw);
        yb  = ceil_log2(bh);
        // drop one y bit for heights just past a power of two
        pow_h = (bh == 0) ? 64'd0 : (64'd1 << yb);
        hh    = pow_h >> 1;
        if (((bh & (bh - 1)) != 0) && bh <= hh + hh / 3 && yb > 3) yb--;
        // pad the row to a whole 64-byte span
        pad = 64'd64 >> p;
        row = bw;
        if ((row & (pad - 1)) != 0) row = (row & ~(pad - 1)) + pad;
        xbase = 4 - longint'(p);
        // interleave low x and y bits pass by pass
        x = 64'(bx); y = 64'(by);
        xcnt = xbase; ycnt = 1; xused = 0; yused = 0;
        addr = 0; guard = 0;
        while (guard < 16 && xused < xbase + 2 && xused + xcnt < xb) begin
            xm = (64'd1 << xcnt) - 1;
            ym = (64'd1 << ycnt) - 1;
            addr |= (x & xm) << (xused + yused);
            addr |= (y & ym) << (xused + yused + xcnt);
            x = x >> xcnt;
            y = y >> ycnt;
            xused += xcnt;
            yused += ycnt;
            t = xb - xused;
            if (t > 1) t = 1;
            if (t < 0) t = 0;
            xcnt = t;
            t = yb - yused;
            if (t > ycnt * 2) t = ycnt * 2;
            if (t < 0) t = 0;
            ycnt = t;
            guard++;
        end
        // remaining high bits form a row-major index
        addr |= (x + y * (row >> xused)) << (xused + yused);
        src = addr * bpb;
        dst = (longint'(by) * bw + longint'(bx)) * bpb;
        r.src     = src[OFF_W-1:0];
        r.dst     = dst[OFF_W-1:0];
        r.copy_ok = (dst + bpb <= 64'(cfg_length)) && (src + bpb <= 64'(cfg_length));
        return r;
    endfunction

    // Drive one register beat and track it in the shadow
    task automatic write_reg(input t_reg_idx idx, input logic [DL_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            REG_IMAGE_WIDTH:  cfg_width  = data[IMG_W-1:0];
            REG_IMAGE_HEIGHT: cfg_height = data[IMG_W-1:0];
            REG_BPB_LOG2:     cfg_bpb    = data[BPB_W-1:0];
            REG_DATA_LENGTH:  cfg_length = data;
            default: ;
        endcase
    endtask

    // Hold input beats until every expected address has come back
    task automatic wait_drain();
        i_s_tvalid <= 1'b0;
        wait (addrs_checked == blocks_sent);
        @(posedge i_clk);
    endtask

    // Reprogram all registers on an idle block
    task automatic load_config(input logic [IMG_W-1:0] w, input logic [IMG_W-1:0] h,
                               input logic [BPB_W-1:0] p, input logic [DL_W-1:0] dl);
        wait_drain();
        write_reg(REG_IMAGE_WIDTH, DL_W'(w));
        write_reg(REG_IMAGE_HEIGHT, DL_W'(h));
        write_reg(REG_BPB_LOG2, DL_W'(p));
        write_reg(REG_DATA_LENGTH, dl);
        i_cfg_valid <= 1'b0;
        // let the derived geometry register the new setting
        repeat (2) @(posedge i_clk);
        settings_used++;
    endtask

    // Send one block coordinate, with random idle cycles ahead of it
    task automatic send_block(input logic [X_W-1:0] bx, input logic [X_W-1:0] by);
        while ($urandom_range(99) < idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        pending_addrs.push_back(predict_offsets(bx, by));
        blocks_sent++;
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {by, bx};
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
    endtask

    // Stall the result side at random and check every accepted beat
    always @(posedge i_clk) begin
        t_blk_addr e;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (pending_addrs.size() == 0) begin
                $error("result beat with no block pending: tdata %h tuser %h",
                       o_m_tdata, o_m_tuser);
                fail_count++;
            end else begin
                e = pending_addrs.pop_front();
                addrs_checked++;
                if (o_m_tdata[27:0] !== e.src) begin
                    $error("source_offset mismatch: expected %h, actual %h",
                           e.src, o_m_tdata[27:0]);
                    fail_count++;
                end
                if (o_m_tdata[55:28] !== e.dst) begin
                    $error("dest_offset mismatch: expected %h, actual %h",
                           e.dst, o_m_tdata[55:28]);
                    fail_count++;
                end
                if (o_m_tuser[0] !== e.copy_ok) begin
                    $error("copy_valid mismatch: expected %b, actual %b",
                           e.copy_ok, o_m_tuser[0]);
                    fail_count++;
                end
            end
        end
        i_m_tready <= ($urandom_range(99) >= stall_pct);
    end

    // Blocks under the reset geometry
    task automatic test_reset_values();
        send_block(12'd0, 12'd0);
        send_block(12'd3, 12'd3);
        send_block(12'hFFF, 12'hFFF);
    endtask

    // Extreme sizes, clamped block sizes and the reduced y bit count
    task automatic test_extremes();
        // oversized image saturates, full data length
        load_config(15'h7FFF, 15'h7FFF, 3'd4, 29'h1FFFFFFF);
        send_block(12'hFFF, 12'hFFF);
        send_block(12'h000, 12'hFFF);
        send_block(12'hFFF, 12'h000);
        send_block(12'hAAA, 12'h555);
        send_block(12'h555, 12'hAAA);
        // zero-sized image, block size below range
        load_config(15'd0, 15'd0, 3'd0, 29'd0);
        send_block(12'd1, 12'd1);
        send_block(12'hFFF, 12'hFFF);
        // block size above range
        load_config(15'd16384, 15'd8, 3'd7, 29'h1FFFFFFF);
        send_block(12'hFFF, 12'd1);
        // 9 block rows: just past a power of two
        load_config(15'd100, 15'd36, 3'd3, 29'h1FFFFFFF);
        send_block(12'd5, 12'd7);
        send_block(12'd24, 12'd8);
        // 33 block rows
        load_config(15'd40, 15'd132, 3'd4, 29'h1FFFFFFF);
        send_block(12'd3, 12'd20);
    endtask

    // Place the data length exactly at, and one byte short of, the block end
    task automatic probe_copy_bound(input logic [X_W-1:0] bx, input logic [X_W-1:0] by,
                                    input logic [BPB_W-1:0] p);
        t_blk_addr       r;
        longint unsigned need;
        load_config(15'd64, 15'd64, p, 29'd0);
        r    = predict_offsets(bx, by);
        need = 64'((r.src > r.dst) ? r.src : r.dst) + (64'd1 << p);
        load_config(15'd64, 15'd64, p, need[DL_W-1:0]);
        send_block(bx, by);
        load_config(15'd64, 15'd64, p, need[DL_W-1:0] - DL_W'(1));
        send_block(bx, by);
    endtask

    task automatic test_copy_bound();
        probe_copy_bound(12'd15, 12'd15, 3'd4);
        probe_copy_bound(12'd3, 12'd9, 3'd4);
        probe_copy_bound(12'd14, 12'd2, 3'd3);
    endtask

    // Random geometry under each pacing mode
    task automatic test_random();
        logic [IMG_W-1:0] w, h;
        logic [BPB_W-1:0] p;
        logic [DL_W-1:0]  dl;
        logic [X_W-1:0]   bx, by;
        longint unsigned  bw, bh, span;
        int               k;
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 59; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 59; end
                default: begin idle_pct = 32; stall_pct = 32; end
            endcase
            for (int s = 0; s < 6; s++) begin
                // sizes: mostly modest, some full range, some heights just past a power of two
                case ($urandom_range(9))
                    0: w = IMG_W'($urandom_range(0, 32767));
                    1: w = 15'd0;
                    default: w = IMG_W'($urandom_range(1, 600));
                endcase
                k = int'($urandom_range(2, 10));
                case ($urandom_range(9))
                    0: h = IMG_W'($urandom_range(0, 32767));
                    1: h = 15'd0;
                    2, 3: h = IMG_W'(4 * ((1 << k) + $urandom_range(1, (1 << k) / 3 + 1)));
                    default: h = IMG_W'($urandom_range(1, 600));
                endcase
                p = BPB_W'(($urandom_range(9) < 8) ? $urandom_range(3, 4)
                                                   : $urandom_range(0, 7));
                span = grid_blocks(w) * grid_blocks(h) * 32;
                if (span == 0) span = 64;
                if (span > 64'h1FFFFFFF) span = 64'h1FFFFFFF;
                if ($urandom_range(3) == 0) dl = DL_W'($urandom());
                else dl = DL_W'($urandom_range(0, 32'(span)));
                load_config(w, h, p, dl);
                bw = grid_blocks(cfg_width);
                bh = grid_blocks(cfg_height);
                for (int n = 0; n < 18; n++) begin
                    if (bw == 0 || $urandom_range(4) == 0) bx = X_W'($urandom_range(0, 4095));
                    else bx = X_W'($urandom_range(0, 32'(bw - 1)));
                    if (bh == 0 || $urandom_range(4) == 0) by = X_W'($urandom_range(0, 4095));
                    else by = X_W'($urandom_range(0, 32'(bh - 1)));
                    send_block(bx, by);
                    // pause the sender until the pipeline is empty
                    if (ph == 1 && s == 3 && n == 9) wait_drain();
                end
            end
        end
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_values();
        test_extremes();
        test_copy_bound();
        test_random();
        wait_drain();
        repeat (6) @(posedge i_clk);
        if (pending_addrs.size() != 0) begin
            $error("%0d block addresses never arrived", pending_addrs.size());
            fail_count++;
        end
        $display("Checked %0d block addresses over %0d register settings,", addrs_checked,
                 settings_used);
        $display("with saturated, empty and near-power-of-two grids under four pacing modes.");
        if (fail_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    // Guard against a hung handshake
    initial begin
        #2_000_000;
        $error("timeout: %0d of %0d block addresses returned", addrs_checked, blocks_sent);
        $display("Some tests failed");
        $finish;
    end

endmodule
